// ===== rtl/cstf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Command text safety filter package
// Shared types, pattern tables and the bit-parallel matcher step function.
// ----------------------------------------------------------------------------
package cstf_pkg;

  localparam int MAX_TEXT_LEN_DEF = 256;
  localparam int PAT_MAX          = 16;
  localparam int NUM_PAT          = 19;
  localparam int NUM_BLOCK        = 11;
  localparam int FIRST_PIPE       = 9;
  localparam int WARN_BASE        = 11;
  localparam int QUEUE_DEPTH      = 2;

  // item kinds handed from the front to the back
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_EXAM = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  // block reasons
  localparam logic [2:0] REASON_NONE  = 3'd0;
  localparam logic [2:0] REASON_RM_RF = 3'd1;
  localparam logic [2:0] REASON_MKFS  = 3'd2;
  localparam logic [2:0] REASON_DD_IF = 3'd3;
  localparam logic [2:0] REASON_DEV   = 3'd4;
  localparam logic [2:0] REASON_FORK  = 3'd5;
  localparam logic [2:0] REASON_PIPE  = 3'd6;

  // pattern element codes
  localparam logic [7:0] CH_WS1   = 8'h20;  // one or more whitespace
  localparam logic [7:0] CH_WS0   = 8'h7E;  // zero or more whitespace
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic       ws;
    logic       alnum;
    logic       last;
  } item_t;

  typedef logic [PAT_MAX-1:0] prog_t;

  // Strings are right-justified: element i of a pattern of length L sits at
  // byte L-1-i. Order follows the found-flag bits.
  localparam logic [PAT_MAX*8-1:0] PAT_TEXT [NUM_PAT] = '{
    "RM -RF", "MKFS", "DD IF=", "> /DEV/SD", ">/DEV/SD",
    ":(){", ":|:&", "CURL", "WGET", "|~SH", "|~BASH",
    "SUDO", "CHMOD 777", "CHOWN ROOT", "PASSWORD~=", "TOKEN~=",
    "API_KEY~=", "SECRET~=", {"PRIVATE", "_KEY~="}
  };

  localparam int PAT_LEN [NUM_PAT] = '{
    6, 4, 6, 9, 8, 4, 4, 4, 4, 4, 6,
    4, 9, 10, 10, 7, 9, 8, 13
  };

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Advance one pattern's progress vector by one byte.
  function automatic prog_t pat_step(input int k, input prog_t old,
                                     input logic [7:0] c, input logic ws);
    prog_t      nw;
    prog_t      prev;
    logic [7:0] e;
    logic       hit;
    logic       last_hit;
    int         len;
    int         idx;
    nw       = '0;
    prev     = {old[PAT_MAX-2:0], 1'b1};
    last_hit = 1'b0;
    len      = PAT_LEN[k];
    for (int i = 0; i < PAT_MAX; i++) begin
      idx = (i < len) ? (len - 1 - i) : 0;
      e   = PAT_TEXT[k][idx*8 +: 8];
      hit = 1'b0;
      if (i < len) begin
        if (e == CH_WS1) begin
          hit = ws && (prev[i] || old[i]);
        end else if (e == CH_WS0) begin
          hit = (ws && (prev[i] || old[i])) || last_hit;
        end else begin
          hit = (c == e) && prev[i];
        end
      end
      nw[i]    = hit;
      last_hit = hit;
    end
    return nw;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/command_text_safety_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Command text safety filter
// Path: a last beat is written into the queue, then on leaving it loads the
//   result register and its valid once that register is free.
// Throughput: one byte beat per cycle unless the full queue stalls input;
//   all 19 matchers advance together per byte; the loop sets no limit.
// Reset: clears length tracking, the queue, all match progress and flags,
//   and the result valid; the first beat may follow right after reset.
// ----------------------------------------------------------------------------
module command_text_safety_filter #(
  parameter int MAX_TEXT_LEN = cstf_pkg::MAX_TEXT_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_safe,
  output logic [2:0]      block_reason,
  output logic            warn_sudo,
  output logic            warn_world_writable,
  output logic            warn_owner_root,
  output logic            warn_credential
);

  // Front: fold case, count examined bytes, spot the zero terminator and
  // tag every beat with its kind plus whitespace and word-char class.
  logic            push;
  cstf_pkg::item_t push_item;
  logic            q_full;

  // Queue: a couple of entries so the front keeps taking beats while the
  // back waits on a stalled result.
  logic            head_valid;
  cstf_pkg::item_t head_item;
  logic            pop;

  cstf_front #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .last_byte (last_byte),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  cstf_queue #(
    .DEPTH (cstf_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // Back: advance the matcher bank per examined byte, hold a pipe token
  // until its boundary, and on the last beat load the result register.
  // A last beat only leaves the queue when the result register is free.
  cstf_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .is_safe             (is_safe),
    .block_reason        (block_reason),
    .warn_sudo           (warn_sudo),
    .warn_world_writable (warn_world_writable),
    .warn_owner_root     (warn_owner_root),
    .warn_credential     (warn_credential)
  );

  // Blocked text never carries warnings.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !is_safe) |->
      !(warn_sudo || warn_world_writable || warn_owner_root || warn_credential))
    else $error("warning reported on blocked text");

  // Safe flag and reason agree.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_safe == (block_reason == cstf_pkg::REASON_NONE)))
    else $error("is_safe disagrees with block_reason");

  // A last beat never overwrites a result still waiting downstream.
  assert property (@(posedge clk) disable iff (rst)
    (pop && head_item.last) |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // Front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");

endmodule
`default_nettype wire

// ===== rtl/cstf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Command text safety filter front end
// Accept byte beats, fold case, track length and end of text, classify.
// ----------------------------------------------------------------------------
module cstf_front #(
  parameter int MAX_TEXT_LEN = cstf_pkg::MAX_TEXT_LEN_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      text_byte,
  input  wire logic            last_byte,
  input  wire logic            q_full,
  output logic                 push,
  output cstf_pkg::item_t      push_item
);

  localparam int CNT_W = (MAX_TEXT_LEN > 2) ? $clog2(MAX_TEXT_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_TEXT_LEN - 1);

  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic             text_ended;
  logic             text_ended_next;
  logic [7:0]       folded;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign folded   = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ?
                    (text_byte - cstf_pkg::CASE_OFS) : text_byte;

  always_comb begin
    byte_count_next = byte_count;
    text_ended_next = text_ended;
    push_item.op    = cstf_pkg::OP_NONE;
    push_item.ch    = folded;
    push_item.ws    = cstf_pkg::is_ws(folded);
    push_item.alnum = cstf_pkg::is_alnum(folded);
    push_item.last  = last_byte;
    if (!text_ended) begin
      if (text_byte == 8'h00) begin
        push_item.op    = cstf_pkg::OP_END;
        text_ended_next = 1'b1;
      end else if (byte_count < CNT_LIMIT) begin
        push_item.op    = cstf_pkg::OP_EXAM;
        byte_count_next = byte_count + 1'b1;
      end
    end
    if (last_byte) begin
      byte_count_next = '0;
      text_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      text_ended <= 1'b0;
    end else if (push) begin
      byte_count <= byte_count_next;
      text_ended <= text_ended_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cstf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Command text safety filter item queue
// Short FIFO between the classifying front and the matcher back end.
// ----------------------------------------------------------------------------
module cstf_queue #(
  parameter int DEPTH = cstf_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire cstf_pkg::item_t push_item,
  output logic                 full,
  output logic                 head_valid,
  output cstf_pkg::item_t      head_item,
  input  wire logic            pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cstf_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_item  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cstf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Command text safety filter back end
// Matcher bank, sticky hit flags, pipe token boundary and result register.
// ----------------------------------------------------------------------------
module cstf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire cstf_pkg::item_t head_item,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic                 is_safe,
  output logic [2:0]           block_reason,
  output logic                 warn_sudo,
  output logic                 warn_world_writable,
  output logic                 warn_owner_root,
  output logic                 warn_credential
);

  localparam int NP = cstf_pkg::NUM_PAT;
  localparam int FP = cstf_pkg::FIRST_PIPE;
  localparam int WB = cstf_pkg::WARN_BASE;

  cstf_pkg::prog_t prog      [NP];
  cstf_pkg::prog_t prog_next [NP];
  logic [NP-1:0]   found;
  logic [NP-1:0]   found_next;
  logic [NP-1:0]   final_flags;
  logic [1:0]      pending;
  logic [1:0]      pending_next;
  logic            out_free;
  logic [2:0]      reason;

  assign out_free = !out_valid || !out_stall;
  assign pop      = head_valid && (!head_item.last || out_free);

  always_comb begin
    prog_next    = prog;
    found_next   = found;
    pending_next = pending;
    case (head_item.op)
      cstf_pkg::OP_EXAM: begin
        // resolve a pending pipe token on a non-word byte
        if (!head_item.alnum) begin
          found_next[FP +: 2] = found[FP +: 2] | pending;
        end
        pending_next = '0;
        for (int k = 0; k < NP; k++) begin
          prog_next[k] = cstf_pkg::pat_step(k, prog[k], head_item.ch, head_item.ws);
          if (prog_next[k][cstf_pkg::PAT_LEN[k]-1]) begin
            if ((k >= FP) && (k < cstf_pkg::NUM_BLOCK)) begin
              pending_next[1'(k - FP)] = 1'b1;
            end else begin
              found_next[k] = 1'b1;
            end
          end
        end
      end
      cstf_pkg::OP_END: begin
        found_next[FP +: 2] = found[FP +: 2] | pending;
        pending_next        = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    final_flags          = found_next;
    final_flags[FP +: 2] = found_next[FP +: 2] | pending_next;
    if (final_flags[0]) begin
      reason = cstf_pkg::REASON_RM_RF;
    end else if (final_flags[1]) begin
      reason = cstf_pkg::REASON_MKFS;
    end else if (final_flags[2]) begin
      reason = cstf_pkg::REASON_DD_IF;
    end else if (final_flags[3] || final_flags[4]) begin
      reason = cstf_pkg::REASON_DEV;
    end else if (final_flags[5] && final_flags[6]) begin
      reason = cstf_pkg::REASON_FORK;
    end else if ((final_flags[7] || final_flags[8]) &&
                 (final_flags[9] || final_flags[10])) begin
      reason = cstf_pkg::REASON_PIPE;
    end else begin
      reason = cstf_pkg::REASON_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NP; k++) begin
        prog[k] <= '0;
      end
      found   <= '0;
      pending <= '0;
    end else if (pop) begin
      if (head_item.last) begin
        for (int k = 0; k < NP; k++) begin
          prog[k] <= '0;
        end
        found   <= '0;
        pending <= '0;
      end else begin
        prog    <= prog_next;
        found   <= found_next;
        pending <= pending_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_item.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      is_safe             <= (reason == cstf_pkg::REASON_NONE);
      block_reason        <= reason;
      warn_sudo           <= (reason == cstf_pkg::REASON_NONE) && final_flags[WB];
      warn_world_writable <= (reason == cstf_pkg::REASON_NONE) && final_flags[WB+1];
      warn_owner_root     <= (reason == cstf_pkg::REASON_NONE) && final_flags[WB+2];
      warn_credential     <= (reason == cstf_pkg::REASON_NONE) &&
                             (final_flags[NP-1:WB+3] != '0);
    end
  end

endmodule
`default_nettype wire
